// ===== hdl/pfbpfa_pkg.sv =====
// Shared types, constants and helpers for the PFB to PFA segment converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package pfbpfa_pkg;

    // Segment framing
    localparam logic [7:0] SEG_MARKER     = 8'd128;
    localparam logic [7:0] SEG_TEXT       = 8'd1;
    localparam logic [7:0] SEG_BINARY     = 8'd2;
    localparam logic [7:0] SEG_END        = 8'd3;

    // Characters
    localparam logic [7:0] CHAR_CR        = 8'd13;
    localparam logic [7:0] CHAR_LF        = 8'd10;
    localparam logic [7:0] CHAR_NONE      = 8'd0;

    // Line length register reset value
    localparam logic [7:0] HEX_LINE_RESET = 8'd40;

    // Status codes
    localparam logic [2:0] ST_RUNNING      = 3'd0;
    localparam logic [2:0] ST_DONE         = 3'd1;
    localparam logic [2:0] ST_BAD_MARKER   = 3'd2;
    localparam logic [2:0] ST_SHORT_LENGTH = 3'd3;
    localparam logic [2:0] ST_SHORT_TEXT   = 3'd4;
    localparam logic [2:0] ST_SHORT_BINARY = 3'd5;
    localparam logic [2:0] ST_BAD_TYPE     = 3'd6;
    localparam logic [2:0] ST_NO_END       = 3'd7;

    // Command queue between parser and output sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Parser phase
    typedef enum logic [2:0] {
        PH_MARKER,
        PH_TYPE,
        PH_LENGTH,
        PH_TEXT,
        PH_BINARY,
        PH_STOPPED
    } t_phase;

    // What the sequencer must emit for one input transaction
    typedef enum logic [1:0] {
        CMD_NONE,    // one result, no character
        CMD_CHAR,    // one result, one character
        CMD_HEX,     // two hex digits
        CMD_HEX_NL   // two hex digits and a line feed
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data;
        logic [2:0]  status;
    } t_cmd;

    // Upper-case hex digit for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pfbpfa_front.sv =====
// Parser front end: accepts input bytes, tracks segment framing and issues
// one command per transaction into the queue. Depends on pfbpfa_pkg.
`default_nettype none

module pfbpfa_front import pfbpfa_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_file,
    input  wire logic       i_cfg_valid,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_q_full,
    output logic            o_in_stall,
    output logic            o_push,
    output t_cmd            o_cmd
);

    t_phase      r_phase, n_phase;
    logic        r_seg_bin, n_seg_bin;
    logic [1:0]  r_len_idx, n_len_idx;
    logic [31:0] r_remain, n_remain;
    logic [7:0]  r_line_cnt, n_line_cnt;
    logic [2:0]  r_status, n_status;
    logic [7:0]  r_line_len;

    logic        accept;
    logic [31:0] len_asm;
    logic [8:0]  cnt_inc;
    logic        hex_nl;
    logic        last_byte;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    // Length assembly, little-endian lane write
    always_comb begin
        len_asm = r_remain;
        case (r_len_idx)
            2'd0:    len_asm[7:0]   = i_data_byte;
            2'd1:    len_asm[15:8]  = i_data_byte;
            2'd2:    len_asm[23:16] = i_data_byte;
            default: len_asm[31:24] = i_data_byte;
        endcase
    end

    assign cnt_inc   = {1'b0, r_line_cnt} + 9'd1;
    assign hex_nl    = cnt_inc >= {1'b0, r_line_len};
    assign last_byte = r_remain == 32'd1;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                PH_MARKER: begin
                    if (i_end_of_file || i_data_byte != SEG_MARKER) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    if (i_end_of_file || i_data_byte == SEG_END ||
                        !(i_data_byte inside {SEG_TEXT, SEG_BINARY})) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        n_phase = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (i_end_of_file) begin
                        n_phase = PH_STOPPED;
                    end else if (r_len_idx == 2'd3) begin
                        if (len_asm == 32'd0) begin
                            n_phase = PH_MARKER;
                        end else if (r_seg_bin) begin
                            n_phase = PH_BINARY;
                        end else begin
                            n_phase = PH_TEXT;
                        end
                    end
                end
                PH_TEXT, PH_BINARY: begin
                    if (i_end_of_file) begin
                        n_phase = PH_STOPPED;
                    end else if (last_byte) begin
                        n_phase = PH_MARKER;
                    end
                end
                default: n_phase = PH_STOPPED;
            endcase
        end
    end

    // Datapath updates and command
    always_comb begin
        n_seg_bin   = r_seg_bin;
        n_len_idx   = r_len_idx;
        n_remain    = r_remain;
        n_line_cnt  = r_line_cnt;
        n_status    = r_status;
        o_cmd.kind  = CMD_NONE;
        o_cmd.data  = CHAR_NONE;
        if (accept) begin
            case (r_phase)
                PH_MARKER: begin
                    if (i_end_of_file) begin
                        n_status = ST_NO_END;
                    end else if (i_data_byte != SEG_MARKER) begin
                        n_status = ST_BAD_MARKER;
                    end
                end
                PH_TYPE: begin
                    if (i_end_of_file ||
                        !(i_data_byte inside {SEG_TEXT, SEG_BINARY, SEG_END})) begin
                        n_status = ST_BAD_TYPE;
                    end else if (i_data_byte == SEG_END) begin
                        n_status = ST_DONE;
                    end else begin
                        n_seg_bin = i_data_byte == SEG_BINARY;
                        n_len_idx = 2'd0;
                        n_remain  = 32'd0;
                    end
                end
                PH_LENGTH: begin
                    if (i_end_of_file) begin
                        n_status = ST_SHORT_LENGTH;
                    end else begin
                        n_remain = len_asm;
                        if (r_len_idx == 2'd3) begin
                            n_len_idx  = 2'd0;
                            n_line_cnt = 8'd0;
                        end else begin
                            n_len_idx = r_len_idx + 2'd1;
                        end
                    end
                end
                PH_TEXT: begin
                    if (i_end_of_file) begin
                        n_status = ST_SHORT_TEXT;
                    end else begin
                        n_remain   = r_remain - 32'd1;
                        o_cmd.kind = CMD_CHAR;
                        o_cmd.data = (i_data_byte == CHAR_CR) ? CHAR_LF : i_data_byte;
                    end
                end
                PH_BINARY: begin
                    if (i_end_of_file) begin
                        n_status = ST_SHORT_BINARY;
                    end else begin
                        n_remain   = r_remain - 32'd1;
                        n_line_cnt = hex_nl ? 8'd0 : cnt_inc[7:0];
                        o_cmd.kind = hex_nl ? CMD_HEX_NL : CMD_HEX;
                        o_cmd.data = i_data_byte;
                    end
                end
                default: ;
            endcase
        end
        o_cmd.status = n_status;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MARKER;
            r_seg_bin  <= 1'b0;
            r_len_idx  <= 2'd0;
            r_remain   <= 32'd0;
            r_line_cnt <= 8'd0;
            r_status   <= ST_RUNNING;
            r_line_len <= HEX_LINE_RESET;
        end else begin
            r_phase    <= n_phase;
            r_seg_bin  <= n_seg_bin;
            r_len_idx  <= n_len_idx;
            r_remain   <= n_remain;
            r_line_cnt <= n_line_cnt;
            r_status   <= n_status;
            if (i_cfg_valid) begin
                r_line_len <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pfbpfa_queue.sv =====
// Short command queue between the parser and the output sequencer.
// Depends on pfbpfa_pkg for the command type and depth.
`default_nettype none

module pfbpfa_queue import pfbpfa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_head
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = r_count == QUEUE_CW'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pfbpfa_back.sv =====
// Output sequencer: expands each queued command into one to three result
// transactions through an output register. Depends on pfbpfa_pkg.
`default_nettype none

module pfbpfa_back import pfbpfa_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_empty,
    input  wire t_cmd       i_head,
    output logic            o_pop,
    input  wire logic       i_out_stall,
    output logic            o_out_valid,
    output logic [7:0]      o_out_char,
    output logic            o_char_valid,
    output logic [2:0]      o_status,
    output logic            o_last
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_cvalid;
    logic [2:0] r_status;
    logic       r_last;
    logic [1:0] r_beat;

    logic       load;
    logic       beat_last;
    logic [7:0] b_char;
    logic       b_cvalid;

    assign load = !r_valid || !i_out_stall;

    // Result for the current beat of the head command
    always_comb begin
        b_char    = CHAR_NONE;
        b_cvalid  = 1'b1;
        beat_last = 1'b1;
        case (i_head.kind)
            CMD_NONE: begin
                b_cvalid = 1'b0;
            end
            CMD_CHAR: begin
                b_char = i_head.data;
            end
            CMD_HEX, CMD_HEX_NL: begin
                case (r_beat)
                    2'd0: begin
                        b_char    = hex_char(i_head.data[7:4]);
                        beat_last = 1'b0;
                    end
                    2'd1: begin
                        b_char    = hex_char(i_head.data[3:0]);
                        beat_last = i_head.kind == CMD_HEX;
                    end
                    default: b_char = CHAR_LF;
                endcase
            end
            default: b_cvalid = 1'b0;
        endcase
    end

    assign o_pop = load && !i_q_empty && beat_last;

    // Output register and beat counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 2'd0;
        end else if (load) begin
            r_valid <= !i_q_empty;
            if (!i_q_empty) begin
                r_beat <= beat_last ? 2'd0 : r_beat + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char   <= b_char;
            r_cvalid <= b_cvalid;
            r_status <= i_head.status;
            r_last   <= beat_last;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_char   = r_char;
    assign o_char_valid = r_cvalid;
    assign o_status     = r_status;
    assign o_last       = r_last;

endmodule

`default_nettype wire

// ===== hdl/pfb_to_pfa_segment_converter_core.sv =====
// PFB to PFA converter top level: parser, command queue, output sequencer.
// A transaction's first result is registered in the queue, then in the output register.
// Throughput: one result per cycle at the output register while i_out_stall is low;
// a transaction gives one result (marker, type, length, text), two (hex) or three (hex + LF).
// Input takes one transaction per cycle while the 4-entry queue has room.
// Reset: synchronous active low; clears state, queue and line length to 40.
`default_nettype none

module pfb_to_pfa_segment_converter_core import pfbpfa_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_file,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_hex_bytes_per_line,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_char_valid,
    output logic [2:0]      o_status,
    output logic            o_last
);

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    assign o_cfg_ready = 1'b1;

    pfbpfa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_hex_bytes_per_line),
        .i_q_full      (q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    pfbpfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    pfbpfa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ===== hdl/pfbpfa_checker.sv =====
// Port-level checker for the converter top level, attached by bind.
// Depends on pfbpfa_pkg for status codes and CHAR_NONE.
`default_nettype none

module pfbpfa_checker import pfbpfa_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_char,
    input wire logic       o_char_valid,
    input wire logic [2:0] o_status,
    input wire logic       o_last
);

    logic       out_xfer;
    logic       r_stopped;
    logic [2:0] r_stop_status;

    assign out_xfer = o_out_valid && !i_out_stall;

    // Remember the first non-running status delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped     <= 1'b0;
            r_stop_status <= ST_RUNNING;
        end else if (out_xfer && !r_stopped && o_status != ST_RUNNING) begin
            r_stopped     <= 1'b1;
            r_stop_status <= o_status;
        end
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_char) &&
        $stable(o_status) && $stable(o_last) && $stable(o_char_valid))
        else $error("output changed while stalled");

    // Once stopped, the status never changes and no character comes out
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_stopped |-> o_status == r_stop_status && !o_char_valid)
        else $error("status changed after stop");

    // A transaction without a character is a single zero result
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !o_char_valid |-> o_out_char == CHAR_NONE && o_last)
        else $error("empty result malformed");

    // Done or error never carries a character
    a_status_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_status != ST_RUNNING |-> !o_char_valid)
        else $error("character with final status");

endmodule

bind pfb_to_pfa_segment_converter_core pfbpfa_checker u_pfbpfa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_char   (o_out_char),
    .o_char_valid (o_char_valid),
    .o_status     (o_status),
    .o_last       (o_last)
);

`default_nettype wire
